// File: sv/pvpc_pkg.sv
package pvpc_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GAIN_X_UNDER = 3'd0;
    localparam logic [2:0] REG_GAIN_X_OVER  = 3'd1;
    localparam logic [2:0] REG_GAIN_Y_UNDER = 3'd2;
    localparam logic [2:0] REG_GAIN_Y_OVER  = 3'd3;
    localparam logic [2:0] REG_Y_ERROR_CAP  = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd5;

    localparam int SPD_W = 13;
    // Internal width for Q.8 components with CORDIC growth headroom.
    localparam int DW = 34;
    // Angle width: 2^32 units per turn, kept signed two bits wider.
    localparam int AW = 34;
    localparam int TAB_LEN = 24;
    localparam logic [16:0] KINV_Q16 = 17'd39797;

    typedef struct packed {
        logic [SPD_W-1:0] target_speed;
        logic signed [15:0] target_direction;
        logic signed [15:0] target_spin;
        logic [SPD_W-1:0] actual_speed;
        logic signed [15:0] actual_direction;
    } in_item_t;

    typedef struct packed {
        logic [SPD_W-1:0] drive_speed;
        logic signed [15:0] drive_direction;
        logic signed [15:0] drive_spin;
    } out_item_t;

    // Arctangent table, 2^32 units per turn.
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h20000000;  1: v = 32'h12E4051D;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2E; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
                15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
                21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_tab = $signed({2'b00, v});
        end
    endfunction

    // Remove the CORDIC gain: (m * KINV + 32768) >>> 16.
    function automatic logic signed [DW-1:0] kscale(input logic signed [DW-1:0] m);
        logic signed [DW+18:0] p;
        begin
            p = m * $signed({1'b0, KINV_Q16}) + (DW+19)'(32768);
            kscale = p[DW+15:16];
        end
    endfunction

endpackage

// File: sv/pvpc_cell.sv
// One CORDIC micro-rotation with a register behind it.
// In rotation mode the sign of z steers; in vectoring mode the sign of y.
module pvpc_cell
    import pvpc_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SIDE_W = 8
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     vectoring,
    input  logic signed [DW-1:0]     x_in,
    input  logic signed [DW-1:0]     y_in,
    input  logic signed [AW-1:0]     z_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic signed [DW-1:0]     x_out,
    output logic signed [DW-1:0]     y_out,
    output logic signed [AW-1:0]     z_out,
    output logic [SIDE_W-1:0]        side_out
);

    logic signed [DW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic [SIDE_W-1:0] side_reg;
    logic down;

    // Pick the rotation direction and rotate.
    always_comb
    begin
        down = vectoring ? (y_in < 0) : !(z_in >= 0);
        if (!down)
        begin
            x_next = vectoring ? x_in + (y_in >>> STEP) : x_in - (y_in >>> STEP);
            y_next = vectoring ? y_in - (x_in >>> STEP) : y_in + (x_in >>> STEP);
            z_next = vectoring ? z_in + atan_tab(STEP) : z_in - atan_tab(STEP);
        end
        else
        begin
            x_next = vectoring ? x_in - (y_in >>> STEP) : x_in + (y_in >>> STEP);
            y_next = vectoring ? y_in + (x_in >>> STEP) : y_in - (x_in >>> STEP);
            z_next = vectoring ? z_in - atan_tab(STEP) : z_in + atan_tab(STEP);
        end
    end

    // The cell only moves on when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            side_reg <= side_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign side_out = side_reg;

endmodule

// File: sv/pvpc_cordic.sv
// A chain of CORDIC cells, one per step, with the pre-rotation in front.
// Rotation mode: x_in is the magnitude, ang16 the heading; gives x, y.
// Vectoring mode: x_in, y_in are the vector; gives scaled magnitude, angle.
module pvpc_cordic
    import pvpc_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int SIDE_W = 8,
    parameter bit VECTORING = 1'b0
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DW-1:0]     x_in,
    input  logic signed [DW-1:0]     y_in,
    input  logic [15:0]              ang16,
    input  logic [SIDE_W-1:0]        side_in,
    output logic signed [DW-1:0]     x_out,
    output logic signed [DW-1:0]     y_out,
    output logic [31:0]              ang_out,
    output logic                     zero_out,
    output logic [SIDE_W-1:0]        side_out
);

    localparam int N = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
    localparam int SW = SIDE_W + 2;

    logic signed [DW-1:0] xs [0:N];
    logic signed [DW-1:0] ys [0:N];
    logic signed [AW-1:0] zs [0:N];
    logic [SW-1:0] ss [0:N];
    logic [31:0] a_rot;
    logic flip, zero;

    // Fold the input into the right half-plane.
    always_comb
    begin
        a_rot = {ang16, 16'h0000};
        zero = 1'b0;
        if (VECTORING)
        begin
            zero = (x_in == '0) && (y_in == '0);
            flip = x_in < 0;
            xs[0] = flip ? -x_in : x_in;
            ys[0] = flip ? -y_in : y_in;
            zs[0] = '0;
        end
        else
        begin
            flip = a_rot[31] ^ a_rot[30];
            if (flip)
                a_rot = a_rot + 32'h80000000;
            xs[0] = x_in;
            ys[0] = '0;
            zs[0] = AW'($signed(a_rot));
        end
        ss[0] = {side_in, flip, zero};
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pvpc_cell #(.STEP(i), .SIDE_W(SW)) u_cell (
            .clk(clk), .en(en), .vectoring(VECTORING),
            .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .side_in(ss[i]),
            .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]), .side_out(ss[i+1])
        );
    end

    // Undo the fold.
    always_comb
    begin
        if (VECTORING)
        begin
            x_out = xs[N];
            y_out = ys[N];
            ang_out = (ss[N][1] ? 32'h80000000 : 32'h0) + zs[N][31:0];
        end
        else
        begin
            x_out = ss[N][1] ? -xs[N] : xs[N];
            y_out = ss[N][1] ? -ys[N] : ys[N];
            ang_out = zs[N][31:0];
        end
        zero_out = ss[N][0];
        side_out = ss[N][SW-1:2];
    end

endmodule

// File: sv/polar_velocity_p_controller_core.sv
// Throughput: one request per cycle unless a held result stalls it; CORDIC cell chains run in a pipeline.
// A stall on the output while a result is presented holds the whole pipeline; the input is then stalled too.
// Reset (rst_n low, asynchronous) clears the valid flags and loads register defaults.
// No clearing pass is needed; the block accepts requests from the first cycle.
module polar_velocity_p_controller_core
    import pvpc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int N = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int LAT = 4 * N + 10;

    // Configuration registers.
    logic [9:0] gxu_reg, gxo_reg, gyu_reg, gyo_reg;
    logic [SPD_W-1:0] ycap_reg, slim_reg;
    logic [2:0] ridx;
    logic wr;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gxu_reg <= 10'd256;
            gxo_reg <= 10'd256;
            gyu_reg <= 10'd256;
            gyo_reg <= 10'd256;
            ycap_reg <= '1;
            slim_reg <= '1;
        end
        else if (wr)
        begin
            case (ridx)
                REG_GAIN_X_UNDER: gxu_reg <= pwdata[9:0];
                REG_GAIN_X_OVER:  gxo_reg <= pwdata[9:0];
                REG_GAIN_Y_UNDER: gyu_reg <= pwdata[9:0];
                REG_GAIN_Y_OVER:  gyo_reg <= pwdata[9:0];
                REG_Y_ERROR_CAP:  ycap_reg <= pwdata[SPD_W-1:0];
                REG_SPEED_LIMIT:  slim_reg <= pwdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_GAIN_X_UNDER: prdata = {22'd0, gxu_reg};
            REG_GAIN_X_OVER:  prdata = {22'd0, gxo_reg};
            REG_GAIN_Y_UNDER: prdata = {22'd0, gyu_reg};
            REG_GAIN_Y_OVER:  prdata = {22'd0, gyo_reg};
            REG_Y_ERROR_CAP:  prdata = {19'd0, ycap_reg};
            REG_SPEED_LIMIT:  prdata = {19'd0, slim_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // The whole pipeline advances unless a finished result is held up.
    logic [LAT-1:0] vld_reg;
    logic adv;
    assign adv = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // The datapath is clocked only when it advances.
    logic gclk_en;
    assign gclk_en = adv;

    // Stage A: the two input vectors to x,y, in parallel chains.
    localparam int SA = 16 + 16 + SPD_W;
    logic signed [DW-1:0] tx, ty, axx, ayy, d0, d1;
    logic [31:0] a0, a1;
    logic z0, z1;
    logic [SA-1:0] sa_out, sa_dummy;
    logic signed [DW-1:0] tmag_in, amag_in;

    assign tmag_in = kscale(DW'($signed({1'b0, in_data.target_speed, 8'h00})));
    assign amag_in = kscale(DW'($signed({1'b0, in_data.actual_speed, 8'h00})));

    logic signed [DW-1:0] tmag_reg, amag_reg;
    in_item_t in_reg;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            tmag_reg <= tmag_in;
            amag_reg <= amag_in;
            in_reg <= in_data;
        end
    end

    pvpc_cordic #(.STEPS(N), .SIDE_W(SA), .VECTORING(1'b0)) u_tgt (
        .clk(clk), .en(gclk_en), .x_in(tmag_reg), .y_in('0),
        .ang16(in_reg.target_direction),
        .side_in({in_reg.target_direction, in_reg.target_spin, in_reg.target_speed}),
        .x_out(tx), .y_out(ty), .ang_out(a0), .zero_out(z0), .side_out(sa_out));
    pvpc_cordic #(.STEPS(N), .SIDE_W(SA), .VECTORING(1'b0)) u_act (
        .clk(clk), .en(gclk_en), .x_in(amag_reg), .y_in('0),
        .ang16(in_reg.actual_direction), .side_in('0),
        .x_out(axx), .y_out(ayy), .ang_out(a1), .zero_out(z1), .side_out(sa_dummy));

    // Stage B: per-axis limit and deadband, gain select.
    function automatic logic signed [DW-1:0] lim_axis(input logic signed [DW-1:0] e);
        logic signed [DW-1:0] m;
        begin
            m = (e < 0) ? -e : e;
            if (m >= DW'(1500 * 256))
                lim_axis = (e < 0) ? -DW'(1400 * 256) : DW'(1400 * 256);
            else if (m <= DW'(50 * 256))
                lim_axis = '0;
            else
                lim_axis = e;
        end
    endfunction

    function automatic logic under_t(input logic signed [DW-1:0] e,
                                     input logic signed [DW-1:0] m);
        logic signed [DW-1:0] ae, am;
        begin
            ae = (e < 0) ? -e : e;
            am = (m < 0) ? -m : m;
            under_t = (((e > 0) && (m > 0)) || ((e < 0) && (m < 0))) && (ae > am);
        end
    endfunction

    logic signed [DW-1:0] ex_b, ey_b, lx_b, ly_b;
    logic [9:0] gx_b, gy_b;
    logic [SA-1:0] sb;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            ex_b <= tx;
            ey_b <= ty;
            lx_b <= lim_axis(tx - axx);
            ly_b <= lim_axis(ty - ayy);
            gx_b <= under_t(tx, axx) ? gxu_reg : gxo_reg;
            gy_b <= under_t(ty, ayy) ? gyu_reg : gyo_reg;
            sb <= sa_out;
        end
    end

    // Stage C: gain product with rounding.
    logic signed [DW-1:0] ex_c, ey_c, erx_c, ery_c;
    logic signed [DW+11:0] px, py;
    logic [SA-1:0] sc;
    assign px = lx_b * $signed({1'b0, gx_b}) + (DW+12)'(128);
    assign py = ly_b * $signed({1'b0, gy_b}) + (DW+12)'(128);
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            ex_c <= ex_b;
            ey_c <= ey_b;
            erx_c <= px[DW+7:8];
            ery_c <= py[DW+7:8];
            sc <= sb;
        end
    end

    // Stage D: y cap.
    logic signed [DW-1:0] ycap_q8, ery_d, erx_d, ex_d, ey_d;
    logic [SA-1:0] sd;
    assign ycap_q8 = DW'($signed({1'b0, ycap_reg, 8'h00}));
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            erx_d <= erx_c;
            ery_d <= (ery_c > ycap_q8) ? ycap_q8 : ery_c;
            ex_d <= ex_c;
            ey_d <= ey_c;
            sd <= sc;
        end
    end

    // Stage E: error to polar form.
    localparam int SE = SA + 2 * DW;
    logic signed [DW-1:0] emx, emy_unused;
    logic [31:0] ez;
    logic ezero;
    logic [SE-1:0] se;
    pvpc_cordic #(.STEPS(N), .SIDE_W(SE), .VECTORING(1'b1)) u_err (
        .clk(clk), .en(gclk_en), .x_in(erx_d), .y_in(ery_d), .ang16('0),
        .side_in({sd, ex_d, ey_d}),
        .x_out(emx), .y_out(emy_unused), .ang_out(ez), .zero_out(ezero),
        .side_out(se));

    // Stage F: magnitude scaling and limits.
    logic signed [DW-1:0] emag_f;
    logic [15:0] edir_f;
    logic [SE-1:0] sf;
    logic signed [DW-1:0] em_k;
    logic [15:0] ed_k;
    always_comb
    begin
        em_k = ezero ? '0 : kscale(emx);
        ed_k = ezero ? 16'd0 : 16'((ez + 32'h8000) >> 16);
        if (em_k >= DW'(2000 * 256))
            em_k = DW'(2000 * 256);
        if (em_k < DW'(50 * 256))
        begin
            em_k = '0;
            ed_k = se[2*DW + SPD_W + 16 +: 16];
        end
    end
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            emag_f <= em_k;
            edir_f <= ed_k;
            sf <= se;
        end
    end

    // Stage G: damping at low target speed.
    logic signed [DW-1:0] emag_g;
    logic [15:0] edir_g;
    logic [SE-1:0] sg;
    logic [SPD_W-1:0] ts_f;
    logic signed [DW+3:0] e5, t1024;
    assign ts_f = sf[2*DW +: SPD_W];
    assign e5 = (DW+4)'(emag_f) * (DW+4)'(5);
    assign t1024 = (DW+4)'($signed({1'b0, ts_f, 10'd0}));
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            emag_g <= ((ts_f < SPD_W'(300)) && (e5 > t1024)) ? (emag_f >>> 1) : emag_f;
            edir_g <= edir_f;
            sg <= sf;
        end
    end

    // Stage H: CORDIC gain compensation ahead of the rotation.
    logic signed [DW-1:0] emag_h;
    logic [15:0] edir_h;
    logic [SE-1:0] sh;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            emag_h <= kscale(emag_g);
            edir_h <= edir_g;
            sh <= sg;
        end
    end

    // Stage I: error back to x,y.
    logic signed [DW-1:0] oxe, oye;
    logic [31:0] a2;
    logic z2;
    logic [SE-1:0] si;
    pvpc_cordic #(.STEPS(N), .SIDE_W(SE), .VECTORING(1'b0)) u_back (
        .clk(clk), .en(gclk_en), .x_in(emag_h), .y_in('0), .ang16(edir_h),
        .side_in(sh), .x_out(oxe), .y_out(oye), .ang_out(a2), .zero_out(z2),
        .side_out(si));

    // Stage J: add to the target vector.
    logic signed [DW-1:0] ox_j, oy_j;
    logic [SA-1:0] sj;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            ox_j <= oxe + si[DW +: DW];
            oy_j <= oye + si[0 +: DW];
            sj <= si[2*DW +: SA];
        end
    end

    // Stage K: output vector to polar form.
    logic signed [DW-1:0] omx, omy_unused;
    logic [31:0] oz;
    logic ozero;
    logic [SA-1:0] sk;
    pvpc_cordic #(.STEPS(N), .SIDE_W(SA), .VECTORING(1'b1)) u_out (
        .clk(clk), .en(gclk_en), .x_in(ox_j), .y_in(oy_j), .ang16('0),
        .side_in(sj), .x_out(omx), .y_out(omy_unused), .ang_out(oz),
        .zero_out(ozero), .side_out(sk));

    // Stage L: gain removal, rounding and clamp.
    logic signed [DW-1:0] om_l;
    logic [15:0] od_l;
    logic [SA-1:0] sl;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            om_l <= ozero ? '0 : kscale(omx);
            od_l <= ozero ? 16'd0 : 16'((oz + 32'h8000) >> 16);
            sl <= sk;
        end
    end

    logic signed [DW-1:0] sp;
    logic [SPD_W-1:0] sp_out;
    logic [15:0] dir_out;
    always_comb
    begin
        sp = (om_l + DW'(128)) >>> 8;
        if (sp >= DW'($signed({1'b0, slim_reg})))
            sp = DW'($signed({1'b0, slim_reg}));
        if (sp < 0)
            sp = '0;
        sp_out = sp[SPD_W-1:0];
        dir_out = (om_l < DW'(256)) ? sl[SPD_W + 16 +: 16] : od_l;
    end

    out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (gclk_en)
        begin
            out_reg.drive_speed <= sp_out;
            out_reg.drive_direction <= dir_out;
            out_reg.drive_spin <= sl[SPD_W +: 16];
        end
    end
    assign out_data = out_reg;

    logic unused_ok;
    assign unused_ok = ^{a0, a1, z0, z1, sa_dummy, emy_unused, a2, z2, omy_unused,
                         paddr[1:0]};

`ifndef NO_ASSERTIONS
    // The input is stalled exactly while a held result waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output hold");
    // A held result stays presented.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("held result changed");
    // An accepted request sets the first valid flag of the pipeline.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted request lost");
`endif

endmodule
